// ===== rtl/core/itp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types and constants for the INI text parser core.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int ENTRY_MAX   = 32;
    localparam int SECTION_LEN = 32;
    localparam int KEY_LEN     = 32;
    localparam int VALUE_LEN   = 64;
    localparam int LINE_MAX    = 128;

    localparam int ENT_W  = 5;
    localparam int CNT_W  = 6;
    localparam int SEC_W  = 5;
    localparam int KEY_W  = 5;
    localparam int VAL_W  = 6;
    localparam int LINE_W = 7;

    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_SKIP  = 3'd1;
    localparam logic [2:0] KIND_SECT  = 3'd2;
    localparam logic [2:0] KIND_ADD   = 3'd3;
    localparam logic [2:0] KIND_OVER  = 3'd4;
    localparam logic [2:0] KIND_FULL  = 3'd5;

    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] PART_SECT = 2'd0;
    localparam logic [1:0] PART_KEY  = 2'd1;
    localparam logic [1:0] PART_VAL  = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;

    typedef struct packed {
        logic       opcode;
        logic [7:0] text_byte;
        logic       last_byte;
        logic [4:0] read_entry;
        logic [1:0] read_part;
        logic [5:0] read_pos;
    } t_in;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [4:0] entry_index;
        logic [5:0] entry_count;
        logic [7:0] read_char;
        logic       text_done;
    } t_out;

    // Trim and split marks gathered over one pass of the line
    typedef struct packed {
        logic              ended;
        logic              nb_seen;
        logic [LINE_W-1:0] lo;
        logic [7:0]        first;
        logic              hi_set;
        logic [LINE_W-1:0] hi;
        logic              eq_found;
        logic              khi_set;
        logic [LINE_W-1:0] khi;
        logic              v_found;
        logic [LINE_W-1:0] vlo;
        logic              close_found;
        logic              s_found;
        logic [LINE_W-1:0] slo;
        logic              shi_set;
        logic [LINE_W-1:0] shi;
    } t_scan;

endpackage

// ===== rtl/core/itp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/itp_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_scan
// Collects trim, '=' and bracket marks from the line bytes, one per cycle.
// ----------------------------------------------------------------------------
module itp_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_valid,
    input  logic [itp_pkg::LINE_W-1:0]  i_idx,
    input  logic [7:0]                  i_byte,
    output itp_pkg::t_scan              o_scan
);

    itp_pkg::t_scan r_s;
    itp_pkg::t_scan n_s;

    logic                       sp;
    logic                       spcr;
    logic                       nb_now;
    logic                       in_sect;
    logic [itp_pkg::LINE_W-1:0] idx_inc;

    always_comb begin
        sp      = (i_byte == itp_pkg::CH_SPACE) || (i_byte == itp_pkg::CH_TAB);
        spcr    = sp || (i_byte == itp_pkg::CH_CR);
        nb_now  = r_s.nb_seen || !sp;
        in_sect = r_s.nb_seen && (r_s.first == itp_pkg::CH_LBRK) && !r_s.close_found;
        idx_inc = i_idx + 1'b1;
        n_s     = r_s;
        if (i_valid && !r_s.ended) begin
            if (i_byte == itp_pkg::CH_NUL) begin
                n_s.ended = 1'b1;
            end else begin
                if (!r_s.nb_seen && !sp) begin
                    n_s.nb_seen = 1'b1;
                    n_s.lo      = i_idx;
                    n_s.first   = i_byte;
                end
                if (nb_now && !spcr) begin
                    n_s.hi_set = 1'b1;
                    n_s.hi     = idx_inc;
                end
                if (nb_now && !r_s.eq_found) begin
                    if (i_byte == itp_pkg::CH_EQ) begin
                        n_s.eq_found = 1'b1;
                    end else if (!spcr) begin
                        n_s.khi_set = 1'b1;
                        n_s.khi     = idx_inc;
                    end
                end
                if (r_s.eq_found && !r_s.v_found && !sp) begin
                    n_s.v_found = 1'b1;
                    n_s.vlo     = i_idx;
                end
                if (in_sect) begin
                    if (i_byte == itp_pkg::CH_RBRK) begin
                        n_s.close_found = 1'b1;
                    end else begin
                        if (!r_s.s_found && !sp) begin
                            n_s.s_found = 1'b1;
                            n_s.slo     = i_idx;
                        end
                        if ((r_s.s_found || !sp) && !spcr) begin
                            n_s.shi_set = 1'b1;
                            n_s.shi     = idx_inc;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_s <= '0;
        end else begin
            r_s <= n_s;
        end
    end

    assign o_scan = r_s;

endmodule

// ===== rtl/core/ini_text_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ini_text_parser_core
// Streaming INI parser holding up to 32 section/key/value entries in RAM.
// ----------------------------------------------------------------------------
// One item is handled at a time. A text byte that does not end a line is
// stored in the line buffer unless it is full or parsing has stopped. A line
// end starts a pass over the line buffer into the mark collector and a decode
// step, then for key=value lines a search of the table (one character of
// section and key compared per cycle through the table RAMs, leaving an entry
// at the first difference), then a write of the 64-byte value slot and, for a
// new entry, of key and section. A section line copies its name into the
// current-section RAM. A read item fetches one table byte. Every result then
// passes to the output register; results leave through that register, and the
// block waits only if it is still full when a new result is ready.
// ----------------------------------------------------------------------------
module ini_text_parser_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  itp_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output itp_pkg::t_out o_out_item
);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDWAIT = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_SECW   = 4'd4;
    localparam logic [3:0] S_CMP    = 4'd5;
    localparam logic [3:0] S_WRV    = 4'd6;
    localparam logic [3:0] S_WRKS   = 4'd7;
    localparam logic [3:0] S_POST   = 4'd8;

    // which table a read item selects
    localparam logic [1:0] RS_NONE = 2'd0;
    localparam logic [1:0] RS_SECT = 2'd1;
    localparam logic [1:0] RS_KEY  = 2'd2;
    localparam logic [1:0] RS_VAL  = 2'd3;

    localparam int LW = itp_pkg::LINE_W;

    logic [3:0]                r_state, n_state;
    logic [LW-1:0]             r_p, n_p;
    logic                      r_d1, n_d1;
    logic [LW-1:0]             r_p1, n_p1;
    logic [itp_pkg::CNT_W-1:0] r_e, n_e;
    logic [itp_pkg::ENT_W-1:0] r_k, n_k;
    logic [LW-1:0]             r_len, n_len;
    logic [LW-1:0]             r_scan_len, n_scan_len;
    logic [itp_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_stopped, n_stopped;
    logic                      r_pending, n_pending;
    logic [itp_pkg::SEC_W-1:0] r_curlen, n_curlen;
    logic [itp_pkg::SEC_W-1:0] r_slen, n_slen;
    logic [itp_pkg::KEY_W-1:0] r_klen, n_klen;
    logic [itp_pkg::VAL_W-1:0] r_vlen, n_vlen;
    logic [LW-1:0]             r_lo, n_lo;
    logic [LW-1:0]             r_vlo, n_vlo;
    logic [LW-1:0]             r_slo, n_slo;
    logic                      r_is_add, n_is_add;
    logic [1:0]                r_rd_sel, n_rd_sel;
    itp_pkg::t_out             r_res, n_res;
    logic                      r_out_valid, n_out_valid;
    itp_pkg::t_out             r_out, n_out;

    // memory ports
    logic          line_we;
    logic [LW-1:0] line_waddr, line_raddr;
    logic [7:0]    line_wdata, line_rd;
    logic          cs_we;
    logic [itp_pkg::SEC_W-1:0] cs_waddr, cs_raddr;
    logic [7:0]    cs_wdata, cs_rd;
    logic          sect_we, key_we, val_we;
    logic [itp_pkg::ENT_W+itp_pkg::SEC_W-1:0] sect_waddr, sect_raddr;
    logic [itp_pkg::ENT_W+itp_pkg::KEY_W-1:0] key_waddr, key_raddr;
    logic [itp_pkg::ENT_W+itp_pkg::VAL_W-1:0] val_waddr, val_raddr;
    logic [7:0]    sect_wdata, key_wdata, val_wdata;
    logic [7:0]    sect_rd, key_rd, val_rd;

    itp_pkg::t_scan scan;
    logic           scan_clear;

    logic                      accept;
    logic                      out_free;
    logic [LW-1:0]             eff_len;
    logic                      eff_stopped;
    logic [LW-1:0]             klen_full, vlen_full, slen_full;
    logic [7:0]                cs_masked, line_kmasked;
    logic                      cmp_ok;
    logic [7:0]                rd_char;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign scan_clear = (r_state == S_IDLE);

    itp_ram #(.WIDTH(8), .DEPTH(itp_pkg::LINE_MAX)) u_line_ram (
        .i_clk(i_clk), .i_we(line_we), .i_waddr(line_waddr), .i_wdata(line_wdata),
        .i_raddr(line_raddr), .o_rdata(line_rd)
    );

    itp_ram #(.WIDTH(8), .DEPTH(itp_pkg::SECTION_LEN)) u_cursec_ram (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(cs_waddr), .i_wdata(cs_wdata),
        .i_raddr(cs_raddr), .o_rdata(cs_rd)
    );

    itp_ram #(.WIDTH(8), .DEPTH(itp_pkg::ENTRY_MAX * itp_pkg::SECTION_LEN)) u_sect_ram (
        .i_clk(i_clk), .i_we(sect_we), .i_waddr(sect_waddr), .i_wdata(sect_wdata),
        .i_raddr(sect_raddr), .o_rdata(sect_rd)
    );

    itp_ram #(.WIDTH(8), .DEPTH(itp_pkg::ENTRY_MAX * itp_pkg::KEY_LEN)) u_key_ram (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(key_wdata),
        .i_raddr(key_raddr), .o_rdata(key_rd)
    );

    itp_ram #(.WIDTH(8), .DEPTH(itp_pkg::ENTRY_MAX * itp_pkg::VALUE_LEN)) u_val_ram (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_waddr), .i_wdata(val_wdata),
        .i_raddr(val_raddr), .o_rdata(val_rd)
    );

    itp_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (scan_clear),
        .i_valid (r_state == S_SCAN && r_d1),
        .i_idx   (r_p1),
        .i_byte  (line_rd),
        .o_scan  (scan)
    );

    // span lengths, later cut in S_DECIDE to the string storage less its terminator
    always_comb begin
        klen_full = scan.khi - scan.lo;
        vlen_full = (scan.v_found && scan.hi_set && (scan.hi > scan.vlo)) ?
                    (scan.hi - scan.vlo) : '0;
        slen_full = scan.shi_set ? (scan.shi - scan.slo) : '0;
    end

    // entry compare: stored strings are zero padded, live ones masked by length
    always_comb begin
        cs_masked    = (r_p1 < {2'b00, r_curlen}) ? cs_rd : itp_pkg::CH_NUL;
        line_kmasked = (r_p1 < {2'b00, r_klen}) ? line_rd : itp_pkg::CH_NUL;
        cmp_ok       = (sect_rd == cs_masked) && (key_rd == line_kmasked);
    end

    always_comb begin
        case (r_rd_sel)
            RS_SECT: rd_char = sect_rd;
            RS_KEY:  rd_char = key_rd;
            RS_VAL:  rd_char = val_rd;
            default: rd_char = itp_pkg::CH_NUL;
        endcase
    end

    assign eff_len     = r_pending ? '0 : r_len;
    assign eff_stopped = r_pending ? 1'b0 : r_stopped;

    always_comb begin
        n_state     = r_state;
        n_p         = r_p;
        n_d1        = r_d1;
        n_p1        = r_p1;
        n_e         = r_e;
        n_k         = r_k;
        n_len       = r_len;
        n_scan_len  = r_scan_len;
        n_count     = r_count;
        n_stopped   = r_stopped;
        n_pending   = r_pending;
        n_curlen    = r_curlen;
        n_slen      = r_slen;
        n_klen      = r_klen;
        n_vlen      = r_vlen;
        n_lo        = r_lo;
        n_vlo       = r_vlo;
        n_slo       = r_slo;
        n_is_add    = r_is_add;
        n_rd_sel    = r_rd_sel;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        line_we    = 1'b0;
        line_waddr = eff_len;
        line_wdata = i_in_item.text_byte;
        line_raddr = r_p;
        cs_we      = 1'b0;
        cs_waddr   = r_p1[itp_pkg::SEC_W-1:0];
        cs_wdata   = line_rd;
        cs_raddr   = r_p[itp_pkg::SEC_W-1:0];
        sect_we    = 1'b0;
        key_we     = 1'b0;
        val_we     = 1'b0;
        sect_waddr = {r_k, r_p1[itp_pkg::SEC_W-1:0]};
        key_waddr  = {r_k, r_p1[itp_pkg::KEY_W-1:0]};
        val_waddr  = {r_k, r_p1[itp_pkg::VAL_W-1:0]};
        sect_wdata = cs_masked;
        key_wdata  = line_kmasked;
        val_wdata  = (r_p1 < {1'b0, r_vlen}) ? line_rd : itp_pkg::CH_NUL;
        sect_raddr = {r_e[itp_pkg::ENT_W-1:0], r_p[itp_pkg::SEC_W-1:0]};
        key_raddr  = {r_e[itp_pkg::ENT_W-1:0], r_p[itp_pkg::KEY_W-1:0]};
        val_raddr  = {i_in_item.read_entry, i_in_item.read_pos};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                sect_raddr = {i_in_item.read_entry, i_in_item.read_pos[itp_pkg::SEC_W-1:0]};
                key_raddr  = {i_in_item.read_entry, i_in_item.read_pos[itp_pkg::KEY_W-1:0]};
                n_res = '0;
                if (accept) begin
                    if (i_in_item.opcode == itp_pkg::OP_READ) begin
                        n_rd_sel = RS_NONE;
                        if ({1'b0, i_in_item.read_entry} < r_count) begin
                            if (i_in_item.read_part == itp_pkg::PART_SECT &&
                                !i_in_item.read_pos[itp_pkg::SEC_W]) begin
                                n_rd_sel = RS_SECT;
                            end else if (i_in_item.read_part == itp_pkg::PART_KEY &&
                                         !i_in_item.read_pos[itp_pkg::KEY_W]) begin
                                n_rd_sel = RS_KEY;
                            end else if (i_in_item.read_part == itp_pkg::PART_VAL) begin
                                n_rd_sel = RS_VAL;
                            end
                        end
                        n_state = S_RDWAIT;
                    end else begin
                        // first byte of a new text wipes table and section
                        if (r_pending) begin
                            n_count   = '0;
                            n_curlen  = '0;
                            n_pending = 1'b0;
                        end
                        n_stopped = eff_stopped;
                        n_len     = eff_len;
                        if (i_in_item.last_byte) begin
                            n_pending = 1'b1;
                        end
                        n_res.text_done = i_in_item.last_byte;
                        if (eff_stopped) begin
                            if (i_in_item.last_byte) begin
                                n_res.result_kind = itp_pkg::KIND_FULL;
                                n_state = S_POST;
                            end
                        end else begin
                            if (i_in_item.text_byte != itp_pkg::CH_LF &&
                                eff_len < LW'(itp_pkg::LINE_MAX - 1)) begin
                                line_we = 1'b1;
                                n_len   = eff_len + 1'b1;
                            end
                            if (i_in_item.text_byte == itp_pkg::CH_LF ||
                                i_in_item.last_byte) begin
                                n_scan_len = (line_we) ? (eff_len + 1'b1) : eff_len;
                                n_len      = '0;
                                n_p        = '0;
                                n_d1       = 1'b0;
                                n_state    = S_SCAN;
                            end
                        end
                    end
                end
            end

            S_RDWAIT: begin
                n_res.result_kind = itp_pkg::KIND_READ;
                n_res.read_char   = rd_char;
                n_state           = S_POST;
            end

            // one line byte per cycle into the mark collector
            S_SCAN: begin
                if (r_p < r_scan_len) begin
                    n_d1 = 1'b1;
                    n_p1 = r_p;
                    n_p  = r_p + 1'b1;
                end else begin
                    n_d1 = 1'b0;
                    if (!r_d1) begin
                        n_state = S_DECIDE;
                    end
                end
            end

            S_DECIDE: begin
                n_p  = '0;
                n_d1 = 1'b0;
                n_e  = '0;
                n_lo  = scan.lo;
                n_vlo = scan.vlo;
                n_slo = scan.slo;
                n_klen = (klen_full > LW'(itp_pkg::KEY_LEN - 1)) ?
                         itp_pkg::KEY_W'(itp_pkg::KEY_LEN - 1) : klen_full[itp_pkg::KEY_W-1:0];
                n_vlen = (vlen_full > LW'(itp_pkg::VALUE_LEN - 1)) ?
                         itp_pkg::VAL_W'(itp_pkg::VALUE_LEN - 1) : vlen_full[itp_pkg::VAL_W-1:0];
                n_slen = (slen_full > LW'(itp_pkg::SECTION_LEN - 1)) ?
                         itp_pkg::SEC_W'(itp_pkg::SECTION_LEN - 1) : slen_full[itp_pkg::SEC_W-1:0];
                n_is_add = 1'b0;
                n_res.result_kind = itp_pkg::KIND_SKIP;
                n_state = S_POST;
                if (!scan.hi_set || scan.first == itp_pkg::CH_SEMI ||
                    scan.first == itp_pkg::CH_HASH) begin
                    n_state = S_POST;
                end else if (scan.first == itp_pkg::CH_LBRK) begin
                    if (scan.close_found) begin
                        n_res.result_kind = itp_pkg::KIND_SECT;
                        n_state = S_SECW;
                    end
                end else if (scan.eq_found && scan.khi_set) begin
                    n_state = S_CMP;
                end
            end

            // copy the trimmed section name into the current-section RAM
            S_SECW: begin
                line_raddr = r_slo + r_p;
                if (r_p < {2'b00, r_slen}) begin
                    n_d1 = 1'b1;
                    n_p1 = r_p;
                    n_p  = r_p + 1'b1;
                end else begin
                    n_d1 = 1'b0;
                end
                if (r_d1) begin
                    cs_we = 1'b1;
                end
                if (!(r_p < {2'b00, r_slen}) && !r_d1) begin
                    n_curlen = r_slen;
                    n_state  = S_POST;
                end
            end

            // walk the entries, one character position per cycle
            S_CMP: begin
                line_raddr = r_lo + r_p;
                if (r_e >= r_count) begin
                    n_d1 = 1'b0;
                    if (r_count >= itp_pkg::CNT_W'(itp_pkg::ENTRY_MAX)) begin
                        n_stopped = 1'b1;
                        n_res.result_kind = itp_pkg::KIND_FULL;
                        n_state = S_POST;
                    end else begin
                        n_k      = r_count[itp_pkg::ENT_W-1:0];
                        n_count  = r_count + 1'b1;
                        n_is_add = 1'b1;
                        n_res.result_kind = itp_pkg::KIND_ADD;
                        n_res.entry_index = r_count[itp_pkg::ENT_W-1:0];
                        n_p      = '0;
                        n_state  = S_WRV;
                    end
                end else if (r_d1 && !cmp_ok) begin
                    n_d1 = 1'b0;
                    n_p  = '0;
                    n_e  = r_e + 1'b1;
                end else if (r_d1 && r_p1 == LW'(itp_pkg::SECTION_LEN - 1)) begin
                    n_d1 = 1'b0;
                    n_p  = '0;
                    n_k  = r_e[itp_pkg::ENT_W-1:0];
                    n_res.result_kind = itp_pkg::KIND_OVER;
                    n_res.entry_index = r_e[itp_pkg::ENT_W-1:0];
                    n_state = S_WRV;
                end else if (r_p < LW'(itp_pkg::SECTION_LEN)) begin
                    n_d1 = 1'b1;
                    n_p1 = r_p;
                    n_p  = r_p + 1'b1;
                end else begin
                    n_d1 = 1'b0;
                end
            end

            // value bytes, zero padded to the full slot
            S_WRV: begin
                line_raddr = r_vlo + r_p;
                if (r_p < LW'(itp_pkg::VALUE_LEN)) begin
                    n_d1 = 1'b1;
                    n_p1 = r_p;
                    n_p  = r_p + 1'b1;
                end else begin
                    n_d1 = 1'b0;
                end
                if (r_d1) begin
                    val_we = 1'b1;
                end
                if (!(r_p < LW'(itp_pkg::VALUE_LEN)) && !r_d1) begin
                    n_p     = '0;
                    n_state = r_is_add ? S_WRKS : S_POST;
                end
            end

            // key and section of a new entry
            S_WRKS: begin
                line_raddr = r_lo + r_p;
                if (r_p < LW'(itp_pkg::KEY_LEN)) begin
                    n_d1 = 1'b1;
                    n_p1 = r_p;
                    n_p  = r_p + 1'b1;
                end else begin
                    n_d1 = 1'b0;
                end
                if (r_d1) begin
                    sect_we = 1'b1;
                    key_we  = 1'b1;
                end
                if (!(r_p < LW'(itp_pkg::KEY_LEN)) && !r_d1) begin
                    n_state = S_POST;
                end
            end

            S_POST: begin
                if (out_free) begin
                    n_out             = r_res;
                    n_out.entry_count = r_count;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_d1        <= 1'b0;
            r_len       <= '0;
            r_count     <= '0;
            r_stopped   <= 1'b0;
            r_pending   <= 1'b1;
            r_curlen    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_d1        <= n_d1;
            r_len       <= n_len;
            r_count     <= n_count;
            r_stopped   <= n_stopped;
            r_pending   <= n_pending;
            r_curlen    <= n_curlen;
            r_out_valid <= n_out_valid;
        end
        r_p        <= n_p;
        r_p1       <= n_p1;
        r_e        <= n_e;
        r_k        <= n_k;
        r_scan_len <= n_scan_len;
        r_slen     <= n_slen;
        r_klen     <= n_klen;
        r_vlen     <= n_vlen;
        r_lo       <= n_lo;
        r_vlo      <= n_vlo;
        r_slo      <= n_slo;
        r_is_add   <= n_is_add;
        r_rd_sel   <= n_rd_sel;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= itp_pkg::CNT_W'(itp_pkg::ENTRY_MAX))
        else $error("entry count beyond table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
        (r_count == $past(r_count) + 1'b1 || r_count == '0))
        else $error("entry count moved by more than one");

    a_no_write_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> !val_we)
        else $error("table written after parse stopped");
`endif

endmodule

// ===== bench/ini_text_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ini_text_parser_checker
// Watches both channels of the INI parser core, keeps its own copy of the
// line buffer and entry table, predicts each result and compares it.
// ----------------------------------------------------------------------------
module ini_text_parser_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  itp_pkg::t_in  i_in_item,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  itp_pkg::t_out i_out_item,
    output int            o_fail_count,
    output int            o_pending
);

    logic [7:0]    line_buf [itp_pkg::LINE_MAX];
    int            line_len;
    logic [7:0]    cur_sect [itp_pkg::SECTION_LEN];
    logic [7:0]    sect_tab [itp_pkg::ENTRY_MAX][itp_pkg::SECTION_LEN];
    logic [7:0]    key_tab  [itp_pkg::ENTRY_MAX][itp_pkg::KEY_LEN];
    logic [7:0]    val_tab  [itp_pkg::ENTRY_MAX][itp_pkg::VALUE_LEN];
    int            n_entries;
    bit            stopped;
    bit            fresh_text;
    itp_pkg::t_out due_results [$];

    function automatic bit blank(logic [7:0] c, bit with_cr);
        return c == itp_pkg::CH_SPACE || c == itp_pkg::CH_TAB ||
               (with_cr && c == itp_pkg::CH_CR);
    endfunction

    function automatic void trim(inout int lo, inout int hi);
        while (lo < hi && blank(line_buf[lo], 0)) lo++;
        while (hi > lo && blank(line_buf[hi-1], 1)) hi--;
    endfunction

    // Returns the result kind of a completed line; idx gets the entry touched
    function automatic logic [2:0] parse_line(output int idx);
        int lo, hi, cl, slo, shi, eq, klo, khi, vlo, vhi, n, hit;
        bit same;
        bit added;
        logic [7:0] key [itp_pkg::KEY_LEN];
        lo = 0; hi = 0; idx = 0;
        while (hi < line_len && line_buf[hi] != itp_pkg::CH_NUL) hi++;
        trim(lo, hi);
        if (lo == hi || line_buf[lo] == itp_pkg::CH_SEMI || line_buf[lo] == itp_pkg::CH_HASH)
            return itp_pkg::KIND_SKIP;
        if (line_buf[lo] == itp_pkg::CH_LBRK) begin
            cl = lo + 1;
            while (cl < hi && line_buf[cl] != itp_pkg::CH_RBRK) cl++;
            if (cl >= hi) return itp_pkg::KIND_SKIP;
            slo = lo + 1; shi = cl;
            trim(slo, shi);
            n = shi - slo;
            for (int i = 0; i < itp_pkg::SECTION_LEN; i++)
                cur_sect[i] = (i < n && i < itp_pkg::SECTION_LEN-1) ? line_buf[slo+i] : 8'h00;
            return itp_pkg::KIND_SECT;
        end
        eq = lo;
        while (eq < hi && line_buf[eq] != itp_pkg::CH_EQ) eq++;
        if (eq >= hi) return itp_pkg::KIND_SKIP;
        klo = lo; khi = eq; vlo = eq + 1; vhi = hi;
        trim(klo, khi);
        trim(vlo, vhi);
        if (klo == khi) return itp_pkg::KIND_SKIP;
        n = khi - klo;
        for (int i = 0; i < itp_pkg::KEY_LEN; i++)
            key[i] = (i < n && i < itp_pkg::KEY_LEN-1) ? line_buf[klo+i] : 8'h00;
        hit = -1;
        for (int e = 0; e < n_entries && hit < 0; e++) begin
            same = 1;
            for (int i = 0; i < itp_pkg::SECTION_LEN; i++)
                if (sect_tab[e][i] !== cur_sect[i]) same = 0;
            for (int i = 0; i < itp_pkg::KEY_LEN; i++)
                if (key_tab[e][i] !== key[i]) same = 0;
            if (same) hit = e;
        end
        added = 0;
        if (hit < 0) begin
            if (n_entries >= itp_pkg::ENTRY_MAX) begin
                stopped = 1;
                return itp_pkg::KIND_FULL;
            end
            hit = n_entries;
            n_entries++;
            for (int i = 0; i < itp_pkg::SECTION_LEN; i++) sect_tab[hit][i] = cur_sect[i];
            for (int i = 0; i < itp_pkg::KEY_LEN; i++) key_tab[hit][i] = key[i];
            added = 1;
        end
        n = vhi - vlo;
        for (int i = 0; i < itp_pkg::VALUE_LEN; i++)
            val_tab[hit][i] = (i < n && i < itp_pkg::VALUE_LEN-1) ? line_buf[vlo+i] : 8'h00;
        idx = hit;
        return added ? itp_pkg::KIND_ADD : itp_pkg::KIND_OVER;
    endfunction

    function automatic void predict_item(itp_pkg::t_in it);
        itp_pkg::t_out r;
        int            idx;
        r = '0;
        if (it.opcode == itp_pkg::OP_READ) begin
            if (it.read_entry < n_entries) begin
                if (it.read_part == itp_pkg::PART_SECT && it.read_pos < itp_pkg::SECTION_LEN)
                    r.read_char = sect_tab[it.read_entry][it.read_pos];
                else if (it.read_part == itp_pkg::PART_KEY && it.read_pos < itp_pkg::KEY_LEN)
                    r.read_char = key_tab[it.read_entry][it.read_pos];
                else if (it.read_part == itp_pkg::PART_VAL)
                    r.read_char = val_tab[it.read_entry][it.read_pos];
            end
            r.result_kind = itp_pkg::KIND_READ;
        end else begin
            if (fresh_text) begin
                n_entries = 0; stopped = 0; line_len = 0;
                foreach (cur_sect[i]) cur_sect[i] = 8'h00;
                fresh_text = 0;
            end
            if (it.last_byte) fresh_text = 1;
            if (stopped) begin
                if (!it.last_byte) return;
                r.result_kind = itp_pkg::KIND_FULL;
            end else begin
                if (it.text_byte != itp_pkg::CH_LF && line_len < itp_pkg::LINE_MAX-1) begin
                    line_buf[line_len] = it.text_byte;
                    line_len++;
                end
                if (it.text_byte != itp_pkg::CH_LF && !it.last_byte) return;
                r.result_kind = parse_line(idx);
                r.entry_index = idx[4:0];
                line_len = 0;
            end
            r.text_done = it.last_byte;
        end
        r.entry_count = n_entries[5:0];
        due_results.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        itp_pkg::t_out want;
        if (!i_rst_n) begin
            line_len   = 0;
            n_entries  = 0;
            stopped    = 0;
            fresh_text = 1;
            foreach (cur_sect[i]) cur_sect[i] = 8'h00;
            due_results.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, i_out_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = due_results.pop_front();
                    if (want !== i_out_item) begin
                        $display("%0t: result mismatch expected %p actual %p",
                                 $time, want, i_out_item);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_item(i_in_item);
            o_pending <= due_results.size();
        end
    end

endmodule

// ===== bench/ini_text_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ini_text_parser_core_tb
// Feeds INI text and read items to the parser core with random gaps and
// output stalls; the checker beside the core does the predicting.
// ----------------------------------------------------------------------------
module ini_text_parser_core_tb;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    itp_pkg::t_in  in_item = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    itp_pkg::t_out out_item;
    int            fail_count;
    int            pending;
    int            cycle_count = 0;
    int            items_sent = 0;
    int            out_wait = 0;

    localparam int CYCLE_LIMIT = 1500000;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ini_text_parser_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    ini_text_parser_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ini_text_parser_core verification failed");
            $finish;
        end
    end

    // Sink: after each item, draw a random wait (or none) and hold ready low until it runs out
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_wait  <= 0;
        end else if (out_valid && out_ready) begin
            w = $urandom_range(0, 4);
            out_ready <= (w == 0);
            out_wait  <= w;
        end else if (!out_ready) begin
            if (out_wait <= 1) begin
                out_ready <= 1'b1;
                out_wait  <= 0;
            end else begin
                out_wait <= out_wait - 1;
            end
        end
    end

    bit no_gaps;

    // Valid stays up after acceptance only when the next item follows at once
    task automatic send_item(itp_pkg::t_in it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        items_sent++;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] b, bit last);
        itp_pkg::t_in it;
        it = itp_pkg::t_in'($urandom);
        it.opcode    = itp_pkg::OP_TEXT;
        it.text_byte = b;
        it.last_byte = last;
        send_item(it);
    endtask

    task automatic send_string(string s, bit end_text);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], end_text && i == s.len() - 1);
    endtask

    task automatic read_char(int e, int part, int pos);
        itp_pkg::t_in it;
        it = itp_pkg::t_in'($urandom);
        it.opcode     = itp_pkg::OP_READ;
        it.read_entry = 5'(e);
        it.read_part  = 2'(part);
        it.read_pos   = 6'(pos);
        send_item(it);
    endtask

    function automatic string word(int max_len);
        string letters;
        string s;
        int n;
        letters = "abcdefgh";
        s = "";
        n = $urandom_range(1, max_len);
        for (int i = 0; i < n; i++)
            s = {s, $sformatf("%c", letters[$urandom_range(0, 7)])};
        return s;
    endfunction

    function automatic string pad();
        case ($urandom_range(0, 3))
            0: return "";
            1: return " ";
            2: return "\t";
            default: return " \t";
        endcase
    endfunction

    initial begin
        string ln;
        int r;
        no_gaps = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: comments, blanks, sections, overwrite, broken lines, CR
        send_string("; note\n# note\n  \t \r\n[ main ]\nk=v\n k = w \r\n", 0);
        send_string("noeq\n=v\n[open\n", 0);
        read_char(0, itp_pkg::PART_SECT, 0);
        read_char(0, itp_pkg::PART_VAL, 0);
        read_char(31, 3, 63);
        send_byte(8'hFF, 0);
        send_byte(8'h00, 1);
        read_char(0, itp_pkg::PART_KEY, 0);

        // Overlong line, then a table overrun
        ln = "";
        for (int i = 0; i < 140; i++) ln = {ln, "x"};
        send_string({ln, "=1\n"}, 0);
        for (int i = 0; i < 34; i++) send_string($sformatf("%0d=\n", i), 0);
        send_string("a=b\n", 0);
        send_string("z", 1);

        // Let everything drain before the random part
        wait_drain();

        r = 0;
        while (items_sent < 445) begin
            no_gaps = (r % 10 == 3);
            case ($urandom_range(0, 9))
                0, 1: send_string({pad(), "[", pad(), word(3), pad(), "]", pad(), "\n"}, 0);
                2, 3, 4, 5:
                    send_string({pad(), word(2), pad(), "=", pad(), word(4), pad(), "\n"}, 0);
                6: begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
                end
                7: send_string("; c\n", $urandom_range(0, 1) == 1);
                default: read_char($urandom_range(0, 31), $urandom_range(0, 3),
                                   $urandom_range(0, 63));
            endcase
            r++;
        end
        no_gaps = 0;
        send_string("end=1", 1);

        wait_drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ini_text_parser_core verification clean");
        else
            $display("ini_text_parser_core verification failed");
        $finish;
    end

endmodule
